// ===== rtl/ipsp_pkg.sv =====
// Package for the IPS / IPS32 patch stream parser.
// Holds parser phase and result kind codes, register indexes, the command and
// configuration structs, and the magic byte tables. No dependencies.
`default_nettype none

package ipsp_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HEADER    = 3'd0,
      PH_ADDR      = 3'd1,
      PH_SIZE      = 3'd2,
      PH_RLE_COUNT = 3'd3,
      PH_RLE_VALUE = 3'd4,
      PH_DATA      = 3'd5,
      PH_STOP      = 3'd6
   } phase_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_WRITE      = 3'd0,
      KIND_FILL       = 3'd1,
      KIND_END        = 3'd2,
      KIND_BAD_HEADER = 3'd3,
      KIND_BAD_CONFIG = 3'd4
   } kind_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAPPED_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_PROTECTED_LIMIT = 2'd1;
   localparam logic [1:0] CSR_BASE_OFFSET     = 2'd2;

   localparam int HEAD_LEN        = 5;
   localparam int TAIL_NARROW_LEN = 3;
   localparam int TAIL_WIDE_LEN   = 4;
   localparam int FIELD_LEN       = 2;

   typedef struct packed {
      logic [31:0] mapped_limit;
      logic [31:0] protected_limit;
      logic [31:0] base_offset;
   } cfg_type;

   // One command from the parser to the address clipper
   typedef struct packed {
      kind_type    kind;
      logic [32:0] addr;
      logic [15:0] count;
      logic [7:0]  value;
   } cmd_type;

   function automatic logic [7:0] head_narrow(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h50; // P
         3'd1:    c = 8'h41; // A
         3'd2:    c = 8'h54; // T
         3'd3:    c = 8'h43; // C
         3'd4:    c = 8'h48; // H
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] head_wide(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h49; // I
         3'd1:    c = 8'h50; // P
         3'd2:    c = 8'h53; // S
         3'd3:    c = 8'h33; // 3
         3'd4:    c = 8'h32; // 2
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] tail_narrow(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h45; // E
         3'd1:    c = 8'h4F; // O
         3'd2:    c = 8'h46; // F
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] tail_wide(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h45; // E
         3'd1:    c = 8'h45; // E
         3'd2:    c = 8'h4F; // O
         3'd3:    c = 8'h46; // F
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ipsp_front.sv =====
// Front end: byte-wise parser of the IPS / IPS32 file structure.
// Turns accepted bytes into commands for the back end. Uses ipsp_pkg.
`default_nettype none

module ipsp_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 byte_fire,
   input  wire  [7:0]          patch_byte,
   input  wire                 start_of_file,
   input  ipsp_pkg::cfg_type   cfg,
   output logic                push,
   output ipsp_pkg::cmd_type   cmd
);

   ipsp_pkg::phase_type phase_ff, phase_in, ph_cur;
   logic [2:0]  idx_ff, idx_in, idx_cur;
   logic        wide_ff, wide_in, wide_cur;
   logic [1:0]  cand_ff, cand_in, cand_cur;
   logic        tail_ff, tail_in, tail_cur;
   logic [31:0] raddr_ff, raddr_in, raddr_cur;
   logic [15:0] rlen_ff, rlen_in, rlen_cur;
   logic [15:0] left_ff, left_in, left_cur;
   logic [32:0] dptr_ff, dptr_in, dptr_cur;

   logic [2:0]  hdr_idx, addr_idx;
   logic [3:0]  hdr_p1, addr_p1, cnt_p1, addr_len;
   logic [1:0]  cand_new;
   logic        tail_new;
   logic [31:0] raddr_shift;
   logic [15:0] rlen_shift, left_shift, left_dec;
   logic        bad_cfg;

   // A start-of-file byte sees the parser as freshly reset
   always_comb begin
      if (start_of_file) begin
         ph_cur    = ipsp_pkg::PH_HEADER;
         idx_cur   = '0;
         wide_cur  = 1'b0;
         cand_cur  = 2'b11;
         tail_cur  = 1'b1;
         raddr_cur = '0;
         rlen_cur  = '0;
         left_cur  = '0;
         dptr_cur  = '0;
      end else begin
         ph_cur    = phase_ff;
         idx_cur   = idx_ff;
         wide_cur  = wide_ff;
         cand_cur  = cand_ff;
         tail_cur  = tail_ff;
         raddr_cur = raddr_ff;
         rlen_cur  = rlen_ff;
         left_cur  = left_ff;
         dptr_cur  = dptr_ff;
      end
   end

   assign addr_len = wide_cur ? 4'(ipsp_pkg::TAIL_WIDE_LEN) : 4'(ipsp_pkg::TAIL_NARROW_LEN);
   assign hdr_idx  = (idx_cur >= 3'(ipsp_pkg::HEAD_LEN)) ? 3'd0 : idx_cur;
   assign addr_idx = ({1'b0, idx_cur} >= addr_len) ? 3'd0 : idx_cur;
   assign hdr_p1   = {1'b0, hdr_idx} + 4'd1;
   assign addr_p1  = {1'b0, addr_idx} + 4'd1;
   assign cnt_p1   = {1'b0, idx_cur} + 4'd1;

   // bit 0: narrow format still possible, bit 1: wide format
   assign cand_new = cand_cur & {patch_byte == ipsp_pkg::head_wide(hdr_idx),
                                 patch_byte == ipsp_pkg::head_narrow(hdr_idx)};
   assign tail_new = tail_cur && (patch_byte == (wide_cur ? ipsp_pkg::tail_wide(addr_idx)
                                                          : ipsp_pkg::tail_narrow(addr_idx)));
   assign raddr_shift = {raddr_cur[23:0], patch_byte};
   assign rlen_shift  = {rlen_cur[7:0], patch_byte};
   assign left_shift  = {left_cur[7:0], patch_byte};
   assign left_dec    = (left_cur != 16'd0) ? left_cur - 16'd1 : left_cur;
   assign bad_cfg     = cfg.base_offset > cfg.protected_limit;

   // Next state
   always_comb begin
      phase_in = ph_cur;
      idx_in   = idx_cur;
      wide_in  = wide_cur;
      cand_in  = cand_cur;
      tail_in  = tail_cur;
      raddr_in = raddr_cur;
      rlen_in  = rlen_cur;
      left_in  = left_cur;
      dptr_in  = dptr_cur;
      unique case (ph_cur)
         ipsp_pkg::PH_HEADER: begin
            idx_in  = hdr_p1[2:0];
            cand_in = cand_new;
            if (hdr_p1 == 4'(ipsp_pkg::HEAD_LEN)) begin
               idx_in = '0;
               if (cand_new == 2'b00) begin
                  phase_in = ipsp_pkg::PH_STOP;
               end else begin
                  wide_in = !cand_new[0];
                  if (bad_cfg) begin
                     phase_in = ipsp_pkg::PH_STOP;
                  end else begin
                     phase_in = ipsp_pkg::PH_ADDR;
                     tail_in  = 1'b1;
                     raddr_in = '0;
                  end
               end
            end
         end
         ipsp_pkg::PH_ADDR: begin
            tail_in  = tail_new;
            raddr_in = raddr_shift;
            idx_in   = addr_p1[2:0];
            if (addr_p1 == addr_len) begin
               idx_in = '0;
               if (tail_new) begin
                  phase_in = ipsp_pkg::PH_STOP;
               end else begin
                  rlen_in  = '0;
                  phase_in = ipsp_pkg::PH_SIZE;
               end
            end
         end
         ipsp_pkg::PH_SIZE: begin
            rlen_in = rlen_shift;
            idx_in  = cnt_p1[2:0];
            if (cnt_p1 >= 4'(ipsp_pkg::FIELD_LEN)) begin
               idx_in = '0;
               if (rlen_shift == 16'd0) begin
                  left_in  = '0;
                  phase_in = ipsp_pkg::PH_RLE_COUNT;
               end else begin
                  left_in  = rlen_shift;
                  dptr_in  = {1'b0, raddr_cur};
                  phase_in = ipsp_pkg::PH_DATA;
               end
            end
         end
         ipsp_pkg::PH_RLE_COUNT: begin
            left_in = left_shift;
            idx_in  = cnt_p1[2:0];
            if (cnt_p1 >= 4'(ipsp_pkg::FIELD_LEN)) begin
               idx_in   = '0;
               phase_in = ipsp_pkg::PH_RLE_VALUE;
            end
         end
         ipsp_pkg::PH_RLE_VALUE: begin
            phase_in = ipsp_pkg::PH_ADDR;
            idx_in   = '0;
            tail_in  = 1'b1;
            raddr_in = '0;
         end
         ipsp_pkg::PH_DATA: begin
            dptr_in = dptr_cur + 33'd1;
            left_in = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = ipsp_pkg::PH_ADDR;
               idx_in   = '0;
               tail_in  = 1'b1;
               raddr_in = '0;
            end
         end
         ipsp_pkg::PH_STOP: begin
            phase_in = ipsp_pkg::PH_STOP;
         end
         default: begin
            phase_in = ipsp_pkg::PH_STOP;
         end
      endcase
   end

   // Outputs: commands toward the back end
   always_comb begin
      push      = 1'b0;
      cmd.kind  = ipsp_pkg::KIND_WRITE;
      cmd.addr  = '0;
      cmd.count = '0;
      cmd.value = '0;
      unique case (ph_cur) inside
         ipsp_pkg::PH_HEADER: begin
            if (hdr_p1 == 4'(ipsp_pkg::HEAD_LEN)) begin
               if (cand_new == 2'b00) begin
                  push     = byte_fire;
                  cmd.kind = ipsp_pkg::KIND_BAD_HEADER;
               end else if (bad_cfg) begin
                  push     = byte_fire;
                  cmd.kind = ipsp_pkg::KIND_BAD_CONFIG;
               end
            end
         end
         ipsp_pkg::PH_ADDR: begin
            if (addr_p1 == addr_len && tail_new) begin
               push     = byte_fire;
               cmd.kind = ipsp_pkg::KIND_END;
            end
         end
         ipsp_pkg::PH_RLE_VALUE: begin
            push      = byte_fire;
            cmd.kind  = ipsp_pkg::KIND_FILL;
            cmd.addr  = {1'b0, raddr_cur};
            cmd.count = left_cur;
            cmd.value = patch_byte;
         end
         ipsp_pkg::PH_DATA: begin
            push      = byte_fire;
            cmd.kind  = ipsp_pkg::KIND_WRITE;
            cmd.addr  = dptr_cur;
            cmd.count = 16'd1;
            cmd.value = patch_byte;
         end
         ipsp_pkg::PH_SIZE, ipsp_pkg::PH_RLE_COUNT, ipsp_pkg::PH_STOP: begin
            push = 1'b0;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ipsp_pkg::PH_HEADER;
         idx_ff   <= '0;
         wide_ff  <= 1'b0;
         cand_ff  <= 2'b11;
         tail_ff  <= 1'b1;
         raddr_ff <= '0;
         rlen_ff  <= '0;
         left_ff  <= '0;
         dptr_ff  <= '0;
      end else if (byte_fire) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         wide_ff  <= wide_in;
         cand_ff  <= cand_in;
         tail_ff  <= tail_in;
         raddr_ff <= raddr_in;
         rlen_ff  <= rlen_in;
         left_ff  <= left_in;
         dptr_ff  <= dptr_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ipsp_queue.sv =====
// Command queue between the parser and the address clipper.
// Small register FIFO of ipsp_pkg::cmd_type entries.
`default_nettype none

module ipsp_queue #(
   parameter int DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  ipsp_pkg::cmd_type   push_cmd,
   input  wire                 pop,
   output logic                full,
   output logic                head_valid,
   output ipsp_pkg::cmd_type   head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ipsp_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ipsp_back.sv =====
// Back end: clips write and fill commands against the protected and mapped
// limits, rebases by the base offset and holds the result. Uses ipsp_pkg.
`default_nettype none

module ipsp_back (
   input  wire                 clock,
   input  wire                 reset,
   input  ipsp_pkg::cfg_type   cfg,
   input  wire                 head_valid,
   input  ipsp_pkg::cmd_type   head_cmd,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [31:0]         rsp_write_address,
   output logic [15:0]         rsp_fill_length,
   output logic [7:0]          rsp_write_value
);

   // Stage 1: start raised to the protected limit, end address
   logic                s1_valid_ff;
   ipsp_pkg::kind_type  s1_kind_ff;
   logic [32:0]         s1_start_ff, s1_start_in;
   logic [33:0]         s1_end_ff, s1_end_in;
   logic [7:0]          s1_value_ff;

   // Stage 2: start raised to the base, rebased start and end
   logic                s2_valid_ff;
   ipsp_pkg::kind_type  s2_kind_ff;
   logic                s2_empty_ff, s2_empty_in;
   logic [32:0]         s2_astart_ff, s2_astart_in;
   logic [33:0]         s2_aend_ff, s2_aend_in;
   logic [7:0]          s2_value_ff;

   // Output register
   logic                out_valid_ff;
   logic [2:0]          out_kind_ff, out_kind_in;
   logic [31:0]         out_addr_ff, out_addr_in;
   logic [15:0]         out_len_ff, out_len_in;
   logic [7:0]          out_value_ff, out_value_in;

   logic        out_free, s2_go, s2_free, s1_go, s1_free, emit, status;
   logic [32:0] prot33, base33, start_b;
   logic [33:0] map34, aend_c, astart34;

   assign prot33   = {1'b0, cfg.protected_limit};
   assign base33   = {1'b0, cfg.base_offset};
   assign map34    = {2'b00, cfg.mapped_limit};

   // Stage 1 logic from the queue head
   assign s1_start_in = (head_cmd.addr < prot33) ? prot33 : head_cmd.addr;
   assign s1_end_in   = {1'b0, head_cmd.addr} + {18'd0, head_cmd.count};

   // Stage 2 logic
   assign start_b      = (s1_start_ff < base33) ? base33 : s1_start_ff;
   assign s2_empty_in  = ({1'b0, start_b} >= s1_end_ff);
   assign s2_astart_in = start_b - base33;
   assign s2_aend_in   = s1_end_ff - {1'b0, base33};

   // Output stage logic
   assign status   = s2_kind_ff inside {ipsp_pkg::KIND_END, ipsp_pkg::KIND_BAD_HEADER,
                                        ipsp_pkg::KIND_BAD_CONFIG};
   assign astart34 = {1'b0, s2_astart_ff};
   assign aend_c   = (s2_aend_ff > map34) ? map34 : s2_aend_ff;
   assign emit     = status || (!s2_empty_ff && (astart34 < aend_c));

   always_comb begin
      out_kind_in = 3'(s2_kind_ff);
      if (status) begin
         out_addr_in  = '0;
         out_len_in   = '0;
         out_value_in = '0;
      end else begin
         out_addr_in  = s2_astart_ff[31:0];
         out_len_in   = 16'(aend_c - astart34);
         out_value_in = s2_value_ff;
      end
   end

   // Stall chain: drop clipped commands without using the output register
   assign out_free = !out_valid_ff || rsp_ready;
   assign s2_go    = s2_valid_ff && (!emit || out_free);
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_go;
   assign pop      = head_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= head_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s2_go && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_kind_ff  <= head_cmd.kind;
         s1_start_ff <= s1_start_in;
         s1_end_ff   <= s1_end_in;
         s1_value_ff <= head_cmd.value;
      end
      if (s1_go) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_empty_ff  <= s2_empty_in;
         s2_astart_ff <= s2_astart_in;
         s2_aend_ff   <= s2_aend_in;
         s2_value_ff  <= s1_value_ff;
      end
      if (s2_go && emit && out_free) begin
         out_kind_ff  <= out_kind_in;
         out_addr_ff  <= out_addr_in;
         out_len_ff   <= out_len_in;
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_fill_length   = out_len_ff;
   assign rsp_write_value   = out_value_ff;

endmodule

`default_nettype wire

// ===== rtl/ips_patch_stream_parser.sv =====
// Top level of the IPS / IPS32 patch stream parser.
// Instantiates ipsp_front, ipsp_queue and ipsp_back; uses ipsp_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------
//  req_     | in        | req_valid/req_ready  | patch_byte, start_of_file
//  rsp_     | out       | rsp_valid/rsp_ready  | kind, write_address, fill_length,
//           |           |                      | write_value
//  csr_     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One patch byte is taken per cycle while the command queue is not full; the parser
// decides in that cycle. rsp_valid follows the queue write, two clip stages and the
// output register; the clip pipeline advances one command per cycle unless rsp_ stalls.
// req_ready drops only while the command queue is full; a stalled rsp_ backs up
// through the clip stages into the queue. csr_ writes are taken every cycle.
// Reset is synchronous and clears the parser, queue and registers at once.
`default_nettype none

module ips_patch_stream_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [7:0]   req_patch_byte,
   input  wire          req_start_of_file,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [2:0]   rsp_kind,
   output logic [31:0]  rsp_write_address,
   output logic [15:0]  rsp_fill_length,
   output logic [7:0]   rsp_write_value,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [1:0]   csr_index,
   input  wire  [31:0]  csr_data
);

   ipsp_pkg::cfg_type cfg_ff;
   ipsp_pkg::cmd_type front_cmd, head_cmd;
   logic byte_fire, front_push, queue_full, head_valid, back_pop;

   // Configuration registers; an index past the list is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ipsp_pkg::CSR_MAPPED_LIMIT:    cfg_ff.mapped_limit    <= csr_data;
            ipsp_pkg::CSR_PROTECTED_LIMIT: cfg_ff.protected_limit <= csr_data;
            ipsp_pkg::CSR_BASE_OFFSET:     cfg_ff.base_offset     <= csr_data;
            default: ;
         endcase
      end
   end

   // Hold input while the queue cannot take a command
   assign req_ready = !queue_full;
   assign byte_fire = req_valid && req_ready;

   ipsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_fire     (byte_fire),
      .patch_byte    (req_patch_byte),
      .start_of_file (req_start_of_file),
      .cfg           (cfg_ff),
      .push          (front_push),
      .cmd           (front_cmd)
   );

   ipsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_cmd   (front_cmd),
      .pop        (back_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ipsp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (back_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_fill_length   (rsp_fill_length),
      .rsp_write_value   (rsp_write_value)
   );

endmodule

`default_nettype wire

// ===== rtl/ipsp_checker.sv =====
// Port-level checker for ips_patch_stream_parser, with its bind statement.
// Uses ipsp_pkg for the result kind codes.
`default_nettype none

module ipsp_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_valid,
   input wire         rsp_ready,
   input wire [2:0]   rsp_kind,
   input wire [31:0]  rsp_write_address,
   input wire [15:0]  rsp_fill_length,
   input wire [7:0]   rsp_write_value
);

   // Hold a stalled result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_write_address) && $stable(rsp_fill_length) && $stable(rsp_write_value))
      else $error("stalled result changed");

   a_write_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'(ipsp_pkg::KIND_WRITE) |-> rsp_fill_length == 16'd1)
      else $error("byte write with length other than one");

   a_fill_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'(ipsp_pkg::KIND_FILL) |-> rsp_fill_length != 16'd0)
      else $error("empty fill run delivered");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == 3'(ipsp_pkg::KIND_END) ||
                    rsp_kind == 3'(ipsp_pkg::KIND_BAD_HEADER) ||
                    rsp_kind == 3'(ipsp_pkg::KIND_BAD_CONFIG))
      |-> rsp_write_address == 32'd0 && rsp_fill_length == 16'd0 && rsp_write_value == 8'd0)
      else $error("status result with nonzero fields");

   // First edge out of reset: nothing is waiting yet
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ips_patch_stream_parser ipsp_checker u_ipsp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_write_address (rsp_write_address),
   .rsp_fill_length   (rsp_fill_length),
   .rsp_write_value   (rsp_write_value)
);

`default_nettype wire
